// ----- hdl/bmrp_pkg.sv -----
`default_nettype none

package bmrp_pkg;

   localparam int SAMPLE_W          = 12;
   localparam int MEAN_W            = 12;
   localparam int POWER_W           = 24;
   localparam int BLOCK_SAMPLES_DEF = 64;

   typedef enum logic [2:0] {
      ST_FILL,
      ST_MEAN_GO,
      ST_MEAN,
      ST_PASS,
      ST_DRAIN,
      ST_POWER
   } bmrp_state_type;

   typedef struct packed {
      logic start;
      logic done;
   } bmrp_div_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/bmrp_div.sv -----
`default_nettype none

// Floor division by a fixed divisor: multiply by ceil(2^SHIFT / DIVISOR) and keep
// the bits above SHIFT. The product is built from the low and then the high half
// of the dividend on one shared multiplier; done pulses once the high half has
// been added, and the quotient holds until the next start.
module bmrp_div
   import bmrp_pkg::*;
#(
   parameter int DIVISOR = BLOCK_SAMPLES_DEF,
   parameter int DVD_W   = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   output bmrp_div_ctl_type      status,
   output logic      [DVD_W-1:0] quotient
);

   localparam int SHIFT  = DVD_W + $clog2(DIVISOR);
   localparam int RCP_W  = DVD_W + 1;
   localparam int LO_W   = (DVD_W + 1) / 2;
   localparam int PROD_W = DVD_W + RCP_W;
   localparam int MUL_W  = LO_W + RCP_W;
   localparam longint unsigned RCP_VAL =
      ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_VAL);

   logic [DVD_W-1:0]  dvd_ff;
   logic [PROD_W-1:0] acc_ff;
   logic              busy_ff;
   logic              phase_ff;
   logic              done_ff;
   logic [LO_W-1:0]   mul_a;
   logic [MUL_W-1:0]  mul_p;

   always_comb begin
      mul_a = phase_ff ? LO_W'(dvd_ff[DVD_W-1:LO_W]) : dvd_ff[LO_W-1:0];
      mul_p = MUL_W'(mul_a) * MUL_W'(RCP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            phase_ff <= 1'b0;
         end else if (busy_ff) begin
            phase_ff <= 1'b1;
            if (phase_ff) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Low half first, then add the high half shifted into place.
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
      end else if (busy_ff) begin
         acc_ff <= phase_ff ? acc_ff + (PROD_W'(mul_p) << LO_W) : PROD_W'(mul_p);
      end
   end

   assign status.start = start;
   assign status.done  = done_ff;
   assign quotient     = DVD_W'(acc_ff[PROD_W-1:SHIFT]);

endmodule

`default_nettype wire

// ----- hdl/block_mean_removed_power.sv -----
`default_nettype none

// Channel  | Ports                                  | Direction
// ---------+----------------------------------------+----------
// request  | req_valid, req_ready, req_sample       | in
// response | rsp_valid, rsp_ready, rsp_block_mean,  | out
//          | rsp_block_power                        |
//
// Samples are taken one per cycle while req_ready is high, until the last of a
// block of BLOCK_SAMPLES. The block then runs with req_ready low: the mean
// divide by reciprocal multiply, a pass over the sample RAM (one read port)
// that sums the squared differences from the mean, and the power divide.
// The result sits in an output register; filling of the next block goes on
// while it waits, except for that block's last sample.
// Synchronous active-high reset clears control; the sample RAM is not cleared.
module block_mean_removed_power
   import bmrp_pkg::*;
#(
   parameter int BLOCK_SAMPLES = BLOCK_SAMPLES_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SAMPLE_W-1:0] req_sample,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [MEAN_W-1:0]   rsp_block_mean,
   output logic      [POWER_W-1:0]  rsp_block_power
);

   localparam int CNT_W  = $clog2(BLOCK_SAMPLES + 1);
   localparam int ADDR_W = (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
   localparam int SUM_W  = SAMPLE_W + CNT_W;
   localparam int SQ_W   = POWER_W + CNT_W;
   localparam int DIFF_W = SAMPLE_W + 1;

   logic [SAMPLE_W-1:0] store_mem [BLOCK_SAMPLES];

   bmrp_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    fill_ff;
   logic [CNT_W-1:0]    pass_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SQ_W-1:0]     sqsum_ff;
   logic [SAMPLE_W-1:0] rd_ff;
   logic                rd_vld_ff;
   logic [POWER_W-1:0]  sq_ff;
   logic                sq_vld_ff;
   logic [MEAN_W-1:0]   mean_ff;
   logic [POWER_W-1:0]  power_ff;
   logic                rsp_valid_ff;

   logic                req_xfer;
   logic                last_fill;
   logic                last_pass;
   logic                rd_issue;
   logic                div_start;
   logic [SQ_W-1:0]     div_dividend;
   logic [SQ_W-1:0]     div_quotient;
   bmrp_div_ctl_type    div_status;

   logic signed [DIFF_W-1:0]   diff;
   logic signed [2*DIFF_W-1:0] prod;

   assign last_fill = (fill_ff == CNT_W'(BLOCK_SAMPLES - 1));
   assign last_pass = (pass_ff == CNT_W'(BLOCK_SAMPLES - 1));
   assign req_ready = (state_ff == ST_FILL) && !(rsp_valid_ff && last_fill);
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      rd_issue     = 1'b0;
      div_start    = 1'b0;
      div_dividend = SQ_W'(sum_ff);
      case (state_ff)
         ST_FILL: begin
            if (req_xfer && last_fill) state_in = ST_MEAN_GO;
         end
         ST_MEAN_GO: begin
            div_start = 1'b1;
            state_in  = ST_MEAN;
         end
         ST_MEAN: begin
            if (div_status.done) state_in = ST_PASS;
         end
         ST_PASS: begin
            rd_issue = 1'b1;
            if (last_pass) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // wait for the square pipeline to empty into the accumulator
            div_dividend = sqsum_ff;
            if (!rd_vld_ff && !sq_vld_ff) begin
               div_start = 1'b1;
               state_in  = ST_POWER;
            end
         end
         ST_POWER: begin
            if (div_status.done) state_in = ST_FILL;
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         fill_ff      <= '0;
         pass_ff      <= '0;
         sum_ff       <= '0;
         sqsum_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         sq_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= rd_issue;
         sq_vld_ff <= rd_vld_ff;

         if (req_xfer) begin
            if (last_fill) begin
               fill_ff <= '0;
            end else begin
               fill_ff <= fill_ff + 1'b1;
            end
            sum_ff <= sum_ff + SUM_W'(req_sample);
         end

         if (rd_issue) begin
            pass_ff <= last_pass ? '0 : pass_ff + 1'b1;
         end

         if (sq_vld_ff) sqsum_ff <= sqsum_ff + SQ_W'(sq_ff);

         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         // Block done: raise the result and start the next block clean.
         if (state_ff == ST_POWER && div_status.done) begin
            rsp_valid_ff <= 1'b1;
            sum_ff       <= '0;
            sqsum_ff     <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) store_mem[fill_ff[ADDR_W-1:0]] <= req_sample;
      if (rd_issue) rd_ff <= store_mem[pass_ff[ADDR_W-1:0]];
   end

   always_comb begin
      diff = $signed({1'b0, rd_ff}) - $signed({1'b0, mean_ff});
      prod = diff * diff;
   end

   always_ff @(posedge clock) begin
      sq_ff <= prod[POWER_W-1:0];
      if (state_ff == ST_MEAN && div_status.done) mean_ff <= div_quotient[MEAN_W-1:0];
      if (state_ff == ST_POWER && div_status.done) power_ff <= div_quotient[POWER_W-1:0];
   end

   bmrp_div #(
      .DIVISOR (BLOCK_SAMPLES),
      .DVD_W   (SQ_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_block_mean  = mean_ff;
   assign rsp_block_power = power_ff;

endmodule

`default_nettype wire
